>>> hw/rtl/wass_pkg.sv
// Shared constants, types and helper functions for the windowed-mean admittance block.
// Used by every module under hw/rtl; it depends on nothing else.
`default_nettype none

package wass_pkg;

   localparam int WINDOW     = 10;
   localparam int NUM_AXES   = 6;
   localparam int DATA_W     = 32;
   localparam int SUM_W      = 40;
   localparam int IDX_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int MREM_W     = IDX_W;
   localparam int MSTEP_W    = IDX_W + 2;
   localparam int MEAN_STEPS = SUM_W / 2;
   localparam int MCNT_W     = (MEAN_STEPS > 1) ? $clog2(MEAN_STEPS) : 1;

   localparam int DG_W       = 31;
   localparam int DB_W       = 17;
   localparam int FG_W       = 17;
   localparam int FRAC_W     = 16;
   localparam int VDVD_W     = DATA_W + FRAC_W;
   localparam int VCNT_W     = $clog2(VDVD_W);
   localparam int DRIVE_W    = DATA_W + 1;
   localparam int PROD_W     = FG_W + 1 + DATA_W;
   localparam int WIDE_W     = DATA_W + 4;

   localparam int REQ_W      = 7 * DATA_W;
   localparam int RSP_W      = 9 * DATA_W;
   localparam int CSR_AW     = 4;
   localparam int CSR_DW     = 32;

   localparam logic [MSTEP_W-1:0] WIN_X1 = MSTEP_W'(WINDOW);
   localparam logic [MSTEP_W-1:0] WIN_X2 = MSTEP_W'(2 * WINDOW);
   localparam logic [MSTEP_W-1:0] WIN_X3 = MSTEP_W'(3 * WINDOW);

   localparam logic [DG_W-1:0]        DAMPING_RESET = DG_W'(655360);
   localparam logic [DB_W-1:0]        DB_HIGH_RESET = DB_W'(66);
   localparam logic signed [DB_W-1:0] DB_LOW_RESET  = -DB_W'(66);
   localparam logic [FG_W-1:0]        FOLLOW_RESET  = FG_W'(655);
   localparam logic [DG_W-1:0]        DG_ONE        = DG_W'(1);

   localparam logic signed [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [VDVD_W-1:0]        NEG_LIMIT = VDVD_W'(64'd1 << (DATA_W - 1));
   localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'((64'd1 << FRAC_W) - 1);

   typedef enum logic [1:0] {
      REG_DAMPING = 2'd0,
      REG_DB_HIGH = 2'd1,
      REG_DB_LOW  = 2'd2,
      REG_FOLLOW  = 2'd3
   } reg_index_type;

   typedef enum logic [5:0] {
      M_IDLE   = 6'b000001,
      M_LAUNCH = 6'b000010,
      M_DIV    = 6'b000100,
      M_MUL    = 6'b001000,
      M_ADD    = 6'b010000,
      M_HOLD   = 6'b100000
   } merge_state_type;

   typedef struct packed {
      logic                     done;
      logic signed [DATA_W-1:0] mean;
   } lane_stat_type;

   typedef struct packed {
      logic [DG_W-1:0]        damping;
      logic [DB_W-1:0]        db_high;
      logic signed [DB_W-1:0] db_low;
      logic [FG_W-1:0]        follow;
   } cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] cmd;
      logic signed [DATA_W-1:0] disp;
      logic signed [DATA_W-1:0] vel;
   } result_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      if ((&v[WIDE_W-1:DATA_W-1]) || !(|v[WIDE_W-1:DATA_W-1])) begin
         sat32 = v[DATA_W-1:0];
      end else if (v[WIDE_W-1]) begin
         sat32 = NEG_MIN;
      end else begin
         sat32 = POS_MAX;
      end
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/wass_lane.sv
// One axis lane: sample ring, running sum and a radix-4 serial divider by the window length.
// Depends on wass_pkg.
`default_nettype none

module wass_lane (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [wass_pkg::IDX_W-1:0]        slot,
   input  logic signed [wass_pkg::DATA_W-1:0] sample,
   output wass_pkg::lane_stat_type           stat
);

   logic signed [wass_pkg::DATA_W-1:0] ring_ff [wass_pkg::WINDOW];
   logic signed [wass_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic                               load_ff, busy_ff, done_ff, neg_ff;
   logic [wass_pkg::MCNT_W-1:0]        cnt_ff;
   logic [wass_pkg::SUM_W-1:0]         dvd_ff, dvd_in;
   logic [wass_pkg::MREM_W-1:0]        rem_ff, rem_in;
   logic [wass_pkg::MSTEP_W-1:0]       part, rpart;
   logic [1:0]                         qbits;
   logic [wass_pkg::SUM_W-1:0]         quo;

   assign sum_in = sum_ff - wass_pkg::SUM_W'(ring_ff[slot]) + wass_pkg::SUM_W'(sample);

   always_comb begin
      part = {rem_ff, dvd_ff[wass_pkg::SUM_W-1 -: 2]};
      if (part >= wass_pkg::WIN_X3) begin
         qbits = 2'd3;
         rpart = part - wass_pkg::WIN_X3;
      end else if (part >= wass_pkg::WIN_X2) begin
         qbits = 2'd2;
         rpart = part - wass_pkg::WIN_X2;
      end else if (part >= wass_pkg::WIN_X1) begin
         qbits = 2'd1;
         rpart = part - wass_pkg::WIN_X1;
      end else begin
         qbits = 2'd0;
         rpart = part;
      end
      rem_in = rpart[wass_pkg::MREM_W-1:0];
      dvd_in = {dvd_ff[wass_pkg::SUM_W-3:0], qbits};
      quo    = neg_ff ? (~dvd_ff + 1'b1) : dvd_ff;
   end

   assign stat.done = done_ff;
   assign stat.mean = quo[wass_pkg::DATA_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < wass_pkg::WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
         sum_ff  <= '0;
         load_ff <= 1'b0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         load_ff <= start;
         done_ff <= 1'b0;
         if (start) begin
            ring_ff[slot] <= sample;
            sum_ff        <= sum_in;
         end
         if (load_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == wass_pkg::MCNT_W'(wass_pkg::MEAN_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_ff) begin
         neg_ff <= sum_ff[wass_pkg::SUM_W-1];
         dvd_ff <= sum_ff[wass_pkg::SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/wass_div.sv
// Bit-serial restoring divider for the velocity: 48-bit magnitude over the damping divisor.
// Depends on wass_pkg.
`default_nettype none

module wass_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [wass_pkg::VDVD_W-1:0] dividend,
   input  logic [wass_pkg::DG_W-1:0]   divisor,
   output logic                        done,
   output logic [wass_pkg::VDVD_W-1:0] quotient
);

   logic                        busy_ff, done_ff;
   logic [wass_pkg::VCNT_W-1:0] cnt_ff;
   logic [wass_pkg::VDVD_W-1:0] dvd_ff;
   logic [wass_pkg::DG_W-1:0]   dsr_ff, rem_ff, rem_in;
   logic [wass_pkg::DG_W:0]     part, diff;
   logic                        qbit;

   always_comb begin
      part   = {rem_ff, dvd_ff[wass_pkg::VDVD_W-1]};
      diff   = part - {1'b0, dsr_ff};
      qbit   = (part >= {1'b0, dsr_ff});
      rem_in = qbit ? diff[wass_pkg::DG_W-1:0] : part[wass_pkg::DG_W-1:0];
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == wass_pkg::VCNT_W'(wass_pkg::VDVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[wass_pkg::VDVD_W-2:0], qbit};
         rem_ff <= rem_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/wass_merge.sv
// Merging stage: drive force, deadband, velocity division, follow-gain product and saturation.
// Depends on wass_pkg and wass_div.
`default_nettype none

module wass_merge (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               go,
   input  logic signed [wass_pkg::DATA_W-1:0] mean_a,
   input  logic signed [wass_pkg::DATA_W-1:0] height,
   input  wass_pkg::cfg_type                  cfg,
   input  logic                               take,
   output logic                               res_valid,
   output wass_pkg::result_type               res
);

   wass_pkg::merge_state_type state_ff, state_in;

   logic signed [wass_pkg::DRIVE_W-1:0]               drive_ff;
   logic signed [wass_pkg::DRIVE_W-1:0]               db_hi_x, db_lo_x;
   logic [wass_pkg::DRIVE_W-1:0]                      mag;
   logic                                              dead_ff;
   logic                                              div_done;
   logic [wass_pkg::VDVD_W-1:0]                       quo;
   logic [wass_pkg::DG_W-1:0]                         divisor;
   logic signed [wass_pkg::DATA_W-1:0]                vel_ff, vel_val, disp_ff, cmd_ff;
   logic signed [wass_pkg::PROD_W-1:0]                prod_ff, adj;
   logic signed [wass_pkg::PROD_W-wass_pkg::FRAC_W-1:0] scaled;

   always_comb begin
      mag     = drive_ff[wass_pkg::DRIVE_W-1] ? (~drive_ff + 1'b1) : drive_ff;
      divisor = (cfg.damping == '0) ? wass_pkg::DG_ONE : cfg.damping;
      db_hi_x = wass_pkg::DRIVE_W'(signed'({1'b0, cfg.db_high}));
      db_lo_x = wass_pkg::DRIVE_W'(signed'(cfg.db_low));
      if (dead_ff) begin
         vel_val = '0;
      end else if (!drive_ff[wass_pkg::DRIVE_W-1]) begin
         vel_val = (|quo[wass_pkg::VDVD_W-1:wass_pkg::DATA_W-1]) ?
                   wass_pkg::POS_MAX : quo[wass_pkg::DATA_W-1:0];
      end else begin
         vel_val = (quo > wass_pkg::NEG_LIMIT) ?
                   wass_pkg::NEG_MIN : (~quo[wass_pkg::DATA_W-1:0] + 1'b1);
      end
      adj    = prod_ff + (prod_ff[wass_pkg::PROD_W-1] ? wass_pkg::RND_BIAS : '0);
      scaled = adj[wass_pkg::PROD_W-1:wass_pkg::FRAC_W];
   end

   always_comb begin
      case (state_ff)
         wass_pkg::M_IDLE:   state_in = go ? wass_pkg::M_LAUNCH : wass_pkg::M_IDLE;
         wass_pkg::M_LAUNCH: state_in = wass_pkg::M_DIV;
         wass_pkg::M_DIV:    state_in = div_done ? wass_pkg::M_MUL : wass_pkg::M_DIV;
         wass_pkg::M_MUL:    state_in = wass_pkg::M_ADD;
         wass_pkg::M_ADD:    state_in = wass_pkg::M_HOLD;
         wass_pkg::M_HOLD:   state_in = take ? wass_pkg::M_IDLE : wass_pkg::M_HOLD;
         default:            state_in = wass_pkg::M_IDLE;
      endcase
   end

   wass_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == wass_pkg::M_LAUNCH),
      .dividend ({mag[wass_pkg::DATA_W-1:0], {wass_pkg::FRAC_W{1'b0}}}),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quo)
   );

   assign res_valid = (state_ff == wass_pkg::M_HOLD);
   assign res.vel   = vel_ff;
   assign res.disp  = disp_ff;
   assign res.cmd   = cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wass_pkg::M_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == wass_pkg::M_IDLE && go) begin
         drive_ff <= -wass_pkg::DRIVE_W'(mean_a);
      end
      if (state_ff == wass_pkg::M_LAUNCH) begin
         dead_ff <= (drive_ff > 0 && drive_ff < db_hi_x) ||
                    (drive_ff < 0 && drive_ff > db_lo_x);
      end
      if (state_ff == wass_pkg::M_DIV && div_done) begin
         vel_ff <= vel_val;
      end
      if (state_ff == wass_pkg::M_MUL) begin
         prod_ff <= signed'({1'b0, cfg.follow}) * vel_ff;
         disp_ff <= wass_pkg::sat32(wass_pkg::WIDE_W'(height) + wass_pkg::WIDE_W'(vel_ff));
      end
      if (state_ff == wass_pkg::M_ADD) begin
         cmd_ff <= wass_pkg::sat32(wass_pkg::WIDE_W'(height) + wass_pkg::WIDE_W'(scaled));
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/wrench_average_admittance_step_top.sv
// Top level of the windowed-mean admittance step: stream ports, register port, six lanes, merge.
// Depends on wass_pkg, wass_lane and wass_merge.
//
// Each accepted sample enters a ring of the last ten samples per axis; the block returns the
// windowed mean of all six axes and, from the negated mean of the first force axis, a damped
// velocity with deadband, a displacement target and a commanded height, all Q16.16 and
// saturated. Each item goes from acceptance through the lanes, whose divide by the window
// length retires two quotient bits a cycle, then through the merge stage, whose bit-serial
// velocity divider works at one bit a cycle over a 48-bit dividend, to the output register.
// The block takes one item at a time; the next item is accepted as soon as the previous
// result has moved into the output register, even while that result still waits for its
// transfer. Registers are written over the APB port at byte addresses 0, 4, 8 and 12 and
// read back at the same places.
`default_nettype none

module wrench_average_admittance_step_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // force_a, force_b, force_c, torque_a, torque_b, torque_c, height_now
   input  logic [wass_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // mean_force_a, mean_force_b, mean_force_c, mean_torque_a, mean_torque_b,
   // mean_torque_c, velocity_vertical, displacement_target, height_command
   output logic [wass_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [wass_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [wass_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [wass_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   logic                                 busy_ff;
   logic [wass_pkg::IDX_W-1:0]           ring_index_ff;
   logic signed [wass_pkg::DATA_W-1:0]   height_ff;
   wass_pkg::cfg_type                    cfg_ff;
   logic                                 rsp_valid_ff;
   logic [wass_pkg::RSP_W-1:0]           rsp_data_ff, rsp_data_in;
   logic                                 accept, take, res_valid, csr_write;
   wass_pkg::result_type                 res;
   wass_pkg::lane_stat_type              lane_stat [wass_pkg::NUM_AXES];
   logic [wass_pkg::NUM_AXES-1:0]        lane_done;
   wass_pkg::reg_index_type              reg_index;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !busy_ff;
   assign take       = res_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = wass_pkg::reg_index_type'(csr_paddr[wass_pkg::CSR_AW-1:2]);

   for (genvar k = 0; k < wass_pkg::NUM_AXES; k++) begin : g_lane
      wass_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .start  (accept),
         .slot   (ring_index_ff),
         .sample (req_tdata[k*wass_pkg::DATA_W +: wass_pkg::DATA_W]),
         .stat   (lane_stat[k])
      );
      assign lane_done[k] = lane_stat[k].done;
   end

   wass_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .go        (lane_stat[0].done),
      .mean_a    (lane_stat[0].mean),
      .height    (height_ff),
      .cfg       (cfg_ff),
      .take      (take),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      rsp_data_in = '0;
      for (int k = 0; k < wass_pkg::NUM_AXES; k++) begin
         rsp_data_in[k*wass_pkg::DATA_W +: wass_pkg::DATA_W] = lane_stat[k].mean;
      end
      rsp_data_in[6*wass_pkg::DATA_W +: wass_pkg::DATA_W] = res.vel;
      rsp_data_in[7*wass_pkg::DATA_W +: wass_pkg::DATA_W] = res.disp;
      rsp_data_in[8*wass_pkg::DATA_W +: wass_pkg::DATA_W] = res.cmd;
   end

   always_comb begin
      case (reg_index)
         wass_pkg::REG_DAMPING: csr_prdata = wass_pkg::CSR_DW'(cfg_ff.damping);
         wass_pkg::REG_DB_HIGH: csr_prdata = wass_pkg::CSR_DW'(cfg_ff.db_high);
         wass_pkg::REG_DB_LOW:  csr_prdata = wass_pkg::CSR_DW'(signed'(cfg_ff.db_low));
         wass_pkg::REG_FOLLOW:  csr_prdata = wass_pkg::CSR_DW'(cfg_ff.follow);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         ring_index_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         cfg_ff.damping <= wass_pkg::DAMPING_RESET;
         cfg_ff.db_high <= wass_pkg::DB_HIGH_RESET;
         cfg_ff.db_low  <= wass_pkg::DB_LOW_RESET;
         cfg_ff.follow  <= wass_pkg::FOLLOW_RESET;
      end else begin
         if (accept) begin
            busy_ff       <= 1'b1;
            ring_index_ff <= (ring_index_ff == wass_pkg::IDX_W'(wass_pkg::WINDOW - 1)) ?
                             '0 : ring_index_ff + 1'b1;
         end else if (take) begin
            busy_ff <= 1'b0;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            case (reg_index)
               wass_pkg::REG_DAMPING: cfg_ff.damping <= csr_pwdata[wass_pkg::DG_W-1:0];
               wass_pkg::REG_DB_HIGH: cfg_ff.db_high <= csr_pwdata[wass_pkg::DB_W-1:0];
               wass_pkg::REG_DB_LOW:  cfg_ff.db_low  <= csr_pwdata[wass_pkg::DB_W-1:0];
               wass_pkg::REG_FOLLOW:  cfg_ff.follow  <= csr_pwdata[wass_pkg::FG_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         height_ff <= req_tdata[6*wass_pkg::DATA_W +: wass_pkg::DATA_W];
      end
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_ring_index_range: assert property (@(posedge clock) disable iff (reset)
      ring_index_ff <= wass_pkg::IDX_W'(wass_pkg::WINDOW - 1))
      else $error("ring index left the window");

   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      (lane_done == '0) || (&lane_done))
      else $error("lanes finished out of step");

   a_lane_done_busy: assert property (@(posedge clock) disable iff (reset)
      lane_done[0] |-> busy_ff && !res_valid)
      else $error("lane finished with no item in flight");

   a_take_in_flight: assert property (@(posedge clock) disable iff (reset)
      take |-> busy_ff && !accept)
      else $error("result moved to output register with no item in flight");

endmodule

`default_nettype wire
